@@ rtl/tmb_pkg.sv @@
// Shared constants and types for the tick timer bank.
package tmb_pkg;

  localparam int NUM_TIMERS_DEF  = 8;
  localparam int LIMIT_WIDTH_DEF = 16;

  localparam int OP_W   = 2;
  localparam int CH_W   = 3;
  localparam int SV_W   = 16;
  localparam int MASK_W = 8;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

  typedef struct packed {
    logic tick;
    logic init;
    logic start;
    logic stop;
    logic cyclic;
  } tmb_ctl_t;

endpackage

@@ rtl/tmb_chan.sv @@
// One timer channel: count, limit, mode and enable with its update logic.
module tmb_chan #(
  parameter int LIMIT_WIDTH = tmb_pkg::LIMIT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tmb_pkg::tmb_ctl_t      ctl,
  input  logic [LIMIT_WIDTH-1:0] limit_in,
  output logic                   en_q,
  output logic                   en_nxt,
  output logic                   fired
);

  logic [LIMIT_WIDTH:0]   count_r, count_nxt;
  logic [LIMIT_WIDTH-1:0] limit_r, limit_nxt;
  logic                   cyc_r, cyc_nxt;
  logic                   en_r;

  always_comb begin
    count_nxt = count_r;
    limit_nxt = limit_r;
    cyc_nxt   = cyc_r;
    en_nxt    = en_r;
    fired     = 1'b0;
    if (ctl.tick) begin
      if (en_r) begin
        if (count_r <= {1'b0, limit_r}) begin
          count_nxt = count_r + 1'b1;
        end else begin
          count_nxt = '0;
          fired     = 1'b1;
          if (!cyc_r) begin
            en_nxt = 1'b0;
          end
        end
      end
    end else if (ctl.init) begin
      en_nxt    = 1'b0;
      limit_nxt = limit_in;
      cyc_nxt   = ctl.cyclic;
      count_nxt = '0;
    end else if (ctl.start) begin
      count_nxt = '0;
      en_nxt    = 1'b1;
    end else if (ctl.stop) begin
      en_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= '0;
      cyc_r   <= 1'b0;
      en_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      limit_r <= limit_nxt;
      cyc_r   <= cyc_nxt;
      en_r    <= en_nxt;
    end
  end

  assign en_q = en_r;

endmodule

@@ rtl/multi_channel_tick_timer_bank_unit.sv @@
// Top level of the tick timer bank: input register, channel array, result register.
// Bank of NUM_TIMERS timers driven by commands: tick, init, start and stop. Each
// accepted transaction yields exactly one result transaction holding the fired mask
// of a tick and the enable mask after the command, for channels 0 to 7. A command
// is taken into the input register, evaluated by all channels in parallel and
// lands in the result register, so one transaction is accepted per cycle when the
// result side does not stall; a stall on the result side holds the command in the
// input register. Init, start and stop commands naming a channel at or above
// NUM_TIMERS change nothing; a tick acts on every channel, whatever it names.
module multi_channel_tick_timer_bank_unit #(
  parameter int NUM_TIMERS  = tmb_pkg::NUM_TIMERS_DEF,
  parameter int LIMIT_WIDTH = tmb_pkg::LIMIT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tmb_pkg::OP_W-1:0]   in_opcode,
  input  logic [tmb_pkg::CH_W-1:0]   in_channel,
  input  logic [tmb_pkg::SV_W-1:0]   in_stop_value,
  input  logic                       in_mode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tmb_pkg::MASK_W-1:0] out_fired_mask,
  output logic [tmb_pkg::MASK_W-1:0] out_enabled_mask
);

  logic                       in_v_r;
  logic [tmb_pkg::OP_W-1:0]   op_r;
  logic [tmb_pkg::CH_W-1:0]   ch_r;
  logic [tmb_pkg::SV_W-1:0]   sv_r;
  logic                       mode_r;
  logic                       out_v_r;
  logic [tmb_pkg::MASK_W-1:0] fired_r;
  logic [tmb_pkg::MASK_W-1:0] enabled_r;

  logic                       step;
  logic                       in_take;
  logic [LIMIT_WIDTH-1:0]     limit_in;
  logic [NUM_TIMERS-1:0]      en_cur;
  logic [NUM_TIMERS-1:0]      en_all;
  logic [NUM_TIMERS-1:0]      fired_all;
  logic [tmb_pkg::MASK_W-1:0] fired_mask;
  logic [tmb_pkg::MASK_W-1:0] en_mask;
  logic [tmb_pkg::MASK_W-1:0] en_cur_mask;

  assign step     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !step;
  assign in_take  = in_valid && !in_stall;
  assign limit_in = LIMIT_WIDTH'(sv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_opcode;
      ch_r   <= in_channel;
      sv_r   <= in_stop_value;
      mode_r <= in_mode;
    end
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_chan
    tmb_pkg::tmb_ctl_t ctl;
    logic              sel;

    assign sel        = (int'(ch_r) == i);
    assign ctl.tick   = step && (op_r == tmb_pkg::OP_TICK);
    assign ctl.init   = step && sel && (op_r == tmb_pkg::OP_INIT);
    assign ctl.start  = step && sel && (op_r == tmb_pkg::OP_START);
    assign ctl.stop   = step && sel && (op_r == tmb_pkg::OP_STOP);
    assign ctl.cyclic = mode_r;

    tmb_chan #(
      .LIMIT_WIDTH(LIMIT_WIDTH)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .limit_in (limit_in),
      .en_q     (en_cur[i]),
      .en_nxt   (en_all[i]),
      .fired    (fired_all[i])
    );
  end

  for (genvar j = 0; j < tmb_pkg::MASK_W; j++) begin : g_mask
    if (j < NUM_TIMERS) begin : g_on
      assign fired_mask[j]  = fired_all[j];
      assign en_mask[j]     = en_all[j];
      assign en_cur_mask[j] = en_cur[j];
    end else begin : g_off
      assign fired_mask[j]  = 1'b0;
      assign en_mask[j]     = 1'b0;
      assign en_cur_mask[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      fired_r   <= fired_mask;
      enabled_r <= en_mask;
    end
  end

  assign out_valid        = out_v_r;
  assign out_fired_mask   = fired_r;
  assign out_enabled_mask = enabled_r;

  a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("result register not loaded after a command was evaluated");

  a_cmd_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    step && (op_r != tmb_pkg::OP_TICK) |=> (fired_r == '0))
    else $error("channel fired on a non-tick command");

  a_fire_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> ((fired_r & ~$past(en_cur_mask)) == '0))
    else $error("disabled channel fired");

  a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> $stable(fired_r) && $stable(enabled_r) && out_v_r)
    else $error("stalled result changed");

endmodule
